// ===== rtl/core/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table bracket search package
// Shared widths, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned LEN_CFG_W = 11;
    localparam int unsigned RES_W     = 12;

    // Length register reset value and the lower clamp of the effective length.
    localparam int unsigned LEN_RESET = 2;
    localparam int unsigned LEN_MIN   = 2;

    // Offset added to the length for keys at or above the last entry.
    localparam int unsigned ABOVE_OFS = 2;

    typedef logic signed [KEY_W-1:0] t_value;
    typedef logic [IDX_W-1:0]        t_entry_index;
    typedef logic [LEN_CFG_W-1:0]    t_cfg_len;
    typedef logic signed [RES_W-1:0] t_bracket;

    // Index returned for keys at or below the first entry and for equal neighbors.
    localparam t_bracket BRACKET_LOW = -12'sd2;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        OUT_INSIDE = 2'd0,
        OUT_BELOW  = 2'd1,
        OUT_ABOVE  = 2'd2,
        OUT_DUP    = 2'd3
    } t_outcome;

    // Source of the table read address.
    typedef enum logic [1:0] {
        RD_FIRST = 2'd0,
        RD_LAST  = 2'd1,
        RD_MID   = 2'd2
    } t_rd_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    wr_en;
        logic    search_start;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_first;
        logic    check;
        logic    step;
        logic    res_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic check_hit;
        logic step_last;
    } t_sts;

endpackage

// ===== rtl/core/stbs_in_if.sv =====
// ----------------------------------------------------------------------------
// Sorted table bracket search input channel
// Carries write and search items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stbs_in_if;
    logic                  valid;
    logic                  ready;
    stbs_pkg::t_op          op;
    stbs_pkg::t_entry_index entry_index;
    stbs_pkg::t_value       entry_value;
    stbs_pkg::t_value       search_key;

    modport source (output valid, op, entry_index, entry_value, search_key, input ready);
    modport sink   (input valid, op, entry_index, entry_value, search_key, output ready);
endinterface

// ===== rtl/core/stbs_out_if.sv =====
// ----------------------------------------------------------------------------
// Sorted table bracket search result channel
// Carries the bracket index and outcome code with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stbs_out_if;
    logic               valid;
    logic               ready;
    stbs_pkg::t_bracket bracket_index;
    stbs_pkg::t_outcome outcome;

    modport source (output valid, bracket_index, outcome, input ready);
    modport sink   (input valid, bracket_index, outcome, output ready);
endinterface

// ===== rtl/core/stbs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Sorted table bracket search configuration channel
// Carries the table length register write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stbs_cfg_if;
    logic               valid;
    logic               ready;
    stbs_pkg::t_cfg_len data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted table bracket search controller
// Sequences the boundary reads, the binary search probes and the result hand-off.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  stbs_pkg::t_op  i_in_op,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  stbs_pkg::t_sts i_sts,
    output stbs_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LAST  = 5'b00010,
        S_CHECK = 5'b00100,
        S_STEP  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    stbs_pkg::t_cmd w_cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == stbs_pkg::OP_SEARCH) begin
                        w_cmd.search_start = 1'b1;
                        w_cmd.rd_en        = 1'b1;
                        w_cmd.rd_sel       = stbs_pkg::RD_FIRST;
                        n_state            = S_LAST;
                    end else begin
                        w_cmd.wr_en = 1'b1;
                    end
                end
            end
            S_LAST: begin
                w_cmd.rd_en     = 1'b1;
                w_cmd.rd_sel    = stbs_pkg::RD_LAST;
                w_cmd.cap_first = 1'b1;
                n_state         = S_CHECK;
            end
            S_CHECK: begin
                w_cmd.check  = 1'b1;
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = stbs_pkg::RD_MID;
                n_state      = i_sts.check_hit ? S_DONE : S_STEP;
            end
            S_STEP: begin
                w_cmd.step   = 1'b1;
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = stbs_pkg::RD_MID;
                if (i_sts.step_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Load the result once the output register is free or draining.
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, cleared on transfer.
    assign n_out_valid = w_cmd.res_load | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// ===== rtl/core/stbs_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted table bracket search datapath
// Table memory, length register, search bounds and the result register.
// ----------------------------------------------------------------------------
module stbs_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  stbs_pkg::t_cfg_len     i_cfg_len,
    input  stbs_pkg::t_cmd         i_cmd,
    output stbs_pkg::t_sts         o_sts,
    input  stbs_pkg::t_entry_index i_entry_index,
    input  stbs_pkg::t_value       i_entry_value,
    input  stbs_pkg::t_value       i_search_key,
    output stbs_pkg::t_bracket     o_bracket_index,
    output stbs_pkg::t_outcome     o_outcome
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = LW + 1;
    localparam int CW = (LW > stbs_pkg::LEN_CFG_W) ? LW : stbs_pkg::LEN_CFG_W;
    localparam int RW = stbs_pkg::RES_W;
    localparam int KW = stbs_pkg::KEY_W;

    stbs_pkg::t_cfg_len r_table_length;
    stbs_pkg::t_value   r_key;
    logic [LW-1:0]      r_len;
    logic [AW-1:0]      r_lo;
    logic [LW-1:0]      r_hi;
    logic               r_hi_set;
    logic [AW-1:0]      r_mid;
    stbs_pkg::t_value   r_val_lo;
    stbs_pkg::t_value   r_val_hi;
    stbs_pkg::t_outcome r_outcome;
    stbs_pkg::t_bracket r_bracket;
    stbs_pkg::t_outcome r_res_outcome;

    logic [CW-1:0]      w_cfg_ext;
    logic [LW-1:0]      w_len_eff;
    logic               w_we;
    logic [AW-1:0]      w_raddr;
    logic [KW-1:0]      w_rdata_raw;
    stbs_pkg::t_value   w_rdata;
    logic               w_le_mid;
    logic               w_le_first;
    logic               w_ge_last;
    logic [AW-1:0]      n_lo;
    logic [LW-1:0]      n_hi;
    logic               n_hi_set;
    stbs_pkg::t_value   n_val_lo;
    stbs_pkg::t_value   n_val_hi;
    logic               w_dup;
    logic [LW-1:0]      w_gap;
    logic [AW-1:0]      w_src_lo;
    logic [LW-1:0]      w_src_hi;
    logic [SW-1:0]      w_sum;
    logic [AW-1:0]      w_mid;
    stbs_pkg::t_bracket w_bracket;

    // Table length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= stbs_pkg::t_cfg_len'(stbs_pkg::LEN_RESET);
        end else if (i_cfg_we) begin
            r_table_length <= i_cfg_len;
        end
    end

    // Effective length: the register clamped between LEN_MIN and the table depth.
    assign w_cfg_ext = CW'(r_table_length);

    always_comb begin
        if (w_cfg_ext < CW'(stbs_pkg::LEN_MIN)) begin
            w_len_eff = LW'(stbs_pkg::LEN_MIN);
        end else if (w_cfg_ext > CW'(TABLE_DEPTH)) begin
            w_len_eff = LW'(TABLE_DEPTH);
        end else begin
            w_len_eff = LW'(w_cfg_ext);
        end
    end

    // Writes beyond the table depth are dropped.
    assign w_we = i_cmd.wr_en && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    stbs_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = $signed(w_rdata_raw);

    // Boundary compares against the first and the last entry.
    assign w_le_first = (r_key <= r_val_lo);
    assign w_ge_last  = (r_key >= w_rdata);

    // One binary search step on the probed entry.
    assign w_le_mid = (w_rdata <= r_key);

    always_comb begin
        if (w_le_mid) begin
            n_lo     = r_mid;
            n_val_lo = w_rdata;
            n_hi     = r_hi;
            n_val_hi = r_val_hi;
            n_hi_set = r_hi_set;
        end else begin
            n_lo     = r_lo;
            n_val_lo = r_val_lo;
            n_hi     = LW'(r_mid);
            n_val_hi = w_rdata;
            n_hi_set = 1'b1;
        end
    end

    // The upper bound counts as a table entry only after it moved below the length.
    assign w_dup = n_hi_set && (n_val_hi == n_val_lo);
    assign w_gap = n_hi - LW'(n_lo);

    assign o_sts.check_hit = w_le_first || w_ge_last;
    assign o_sts.step_last = w_dup || (w_gap <= LW'(1));

    // Next probe address from the bounds that hold after this cycle.
    assign w_src_lo = i_cmd.check ? '0 : n_lo;
    assign w_src_hi = i_cmd.check ? r_len : n_hi;
    assign w_sum    = SW'(w_src_lo) + SW'(w_src_hi);
    assign w_mid    = AW'(w_sum >> 1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            stbs_pkg::RD_FIRST: w_raddr = '0;
            stbs_pkg::RD_LAST:  w_raddr = AW'(r_len - LW'(1));
            stbs_pkg::RD_MID:   w_raddr = w_mid;
            default:            w_raddr = '0;
        endcase
    end

    // Search state registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_start) begin
            r_key <= i_search_key;
            r_len <= w_len_eff;
        end
        if (i_cmd.cap_first) begin
            r_val_lo <= w_rdata;
        end
        if (i_cmd.check) begin
            r_lo     <= '0;
            r_hi     <= r_len;
            r_hi_set <= 1'b0;
            r_mid    <= w_mid;
            if (w_le_first) begin
                r_outcome <= stbs_pkg::OUT_BELOW;
            end else if (w_ge_last) begin
                r_outcome <= stbs_pkg::OUT_ABOVE;
            end else begin
                r_outcome <= stbs_pkg::OUT_INSIDE;
            end
        end
        if (i_cmd.step) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_hi_set <= n_hi_set;
            r_val_lo <= n_val_lo;
            r_val_hi <= n_val_hi;
            r_mid    <= w_mid;
            if (w_dup) begin
                r_outcome <= stbs_pkg::OUT_DUP;
            end
        end
    end

    // Result index by outcome.
    always_comb begin
        unique case (r_outcome)
            stbs_pkg::OUT_INSIDE: w_bracket = $signed(RW'(r_lo));
            stbs_pkg::OUT_ABOVE:  w_bracket = $signed(RW'(SW'(r_len) +
                                                         SW'(stbs_pkg::ABOVE_OFS)));
            stbs_pkg::OUT_BELOW:  w_bracket = stbs_pkg::BRACKET_LOW;
            stbs_pkg::OUT_DUP:    w_bracket = stbs_pkg::BRACKET_LOW;
            default:              w_bracket = stbs_pkg::BRACKET_LOW;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_bracket     <= w_bracket;
            r_res_outcome <= r_outcome;
        end
    end

    assign o_bracket_index = r_bracket;
    assign o_outcome       = r_res_outcome;

endmodule

// ===== rtl/core/sorted_table_bracket_search_core.sv =====
// ----------------------------------------------------------------------------
// Sorted table bracket search core
// Keeps an ascending table of signed Q16.16 values and answers bracket queries.
//
// Channels: i_in carries items; op OP_WRITE stores entry_value at entry_index
// (indexes at or beyond TABLE_DEPTH are dropped) and gives no result, op
// OP_SEARCH brackets search_key and gives one result on o_out. i_cfg writes
// the table length, clamped to 2..TABLE_DEPTH when a search starts.
// A write item is taken in the idle state. A search reads the first and the
// last entry; when the key lies at or beyond either of them the result is ready,
// otherwise binary search probes follow, at most ceil(log2(length)) of them.
// The single read port of the table memory sets this order: one probe per cycle,
// after the first and last entry are read.
// A finished result sits in an output register; the core takes the next
// item while it waits. If the receiver stalls and a second result is ready,
// the core holds in its final state until the first one transfers.
// Reset clears the control state and sets the length to 2; table contents
// are undefined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
module sorted_table_bracket_search_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    stbs_cfg_if.sink        i_cfg,
    stbs_in_if.sink         i_in,
    stbs_out_if.source      o_out
);

    stbs_pkg::t_cmd w_cmd;
    stbs_pkg::t_sts w_sts;
    logic           w_in_ready;
    logic           w_out_valid;

    // The length register takes a write in every cycle.
    assign i_cfg.ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_len       (i_cfg.data),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_entry_index   (i_in.entry_index),
        .i_entry_value   (i_in.entry_value),
        .i_search_key    (i_in.search_key),
        .o_bracket_index (o_out.bracket_index),
        .o_outcome       (o_out.outcome)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // A result is loaded only into a free or draining output register.
    a_res_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over a pending result");

    // A loaded result is offered in the next cycle.
    a_res_offered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |=> o_out.valid)
        else $error("loaded result not offered");

    // Below-first and equal-neighbor results carry the low index.
    a_low_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.outcome == stbs_pkg::OUT_BELOW ||
                         o_out.outcome == stbs_pkg::OUT_DUP))
        |-> (o_out.bracket_index == stbs_pkg::BRACKET_LOW))
        else $error("low outcome with wrong index");

    // No new item is taken while a search probes the table.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !i_in.ready)
        else $error("input ready during search");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table bracket search core testbench
// A short directed table covers the field extremes, the length clamp, equal
// neighbors and an unsorted table. Random phases then load ascending tables of
// several lengths and search them with keys aimed at entries, gaps and both ends;
// tables longer than BIG_LENGTH are searched at the two ends only. Results are
// checked in transfer order, against typed expectations or a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH          = 1024;
    localparam int SEARCHES       = 38;
    localparam int SETTLE_CYCLES  = 20;
    localparam int BIG_LENGTH     = 200;
    localparam longint VAL_MIN    = -(longint'(1) <<< 31);
    localparam longint VAL_MAX    = (longint'(1) <<< 31) - 1;

    // One row of the directed part: either a length write or an item.
    typedef struct packed {
        logic                   is_cfg;
        stbs_pkg::t_cfg_len     cfg;
        stbs_pkg::t_op          op;
        stbs_pkg::t_entry_index idx;
        stbs_pkg::t_value       val;
        stbs_pkg::t_value       key;
        logic                   typed;
        stbs_pkg::t_bracket     eidx;
        stbs_pkg::t_outcome     eout;
    } t_stim_row;

    typedef struct packed {
        stbs_pkg::t_bracket idx;
        stbs_pkg::t_outcome oc;
    } t_expect;

    localparam int N_ROWS = 24;
    localparam t_stim_row DIR_ROWS [N_ROWS] = '{
        // Length 2 after reset: extreme values at both ends.
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd0, 32'sh8000_0000, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd1, 32'sh7FFF_FFFF, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh8000_0000,
          1'b1, stbs_pkg::BRACKET_LOW, stbs_pkg::OUT_BELOW},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh7FFF_FFFF,
          1'b1, 12'sd4, stbs_pkg::OUT_ABOVE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh8000_0001,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh7FFF_FFFE,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd1023, 32'sh0001_0000, 32'sh7FFF_FFFF,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        // A length of zero clamps up to two.
        '{1'b1, 11'd0, stbs_pkg::OP_WRITE, 10'd0, 32'sd0, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh7FFF_FFFF,
          1'b1, 12'sd4, stbs_pkg::OUT_ABOVE},
        // Five entries with two equal neighbors in the middle.
        '{1'b1, 11'd5, stbs_pkg::OP_WRITE, 10'd0, 32'sd0, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd0, -32'sd1000, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd1, 32'sh0001_0000, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd2, 32'sh0001_0000, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd3, 32'sh0002_0000, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd4, 32'sh7FFF_FFFF, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh0001_0000,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh0001_8000,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, -32'sd1000,
          1'b1, stbs_pkg::BRACKET_LOW, stbs_pkg::OUT_BELOW},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh7FFF_FFFF,
          1'b1, 12'sd7, stbs_pkg::OUT_ABOVE},
        // Break the ordering and search across the disorder.
        '{1'b0, 11'd0, stbs_pkg::OP_WRITE, 10'd2, 32'sh0003_0000, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh0002_8000,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b0, 11'd0, stbs_pkg::OP_SEARCH, 10'd0, 32'sd0, 32'sh0000_8000,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE},
        '{1'b1, 11'd2, stbs_pkg::OP_WRITE, 10'd0, 32'sd0, 32'sd0,
          1'b0, 12'sd0, stbs_pkg::OUT_INSIDE}
    };

    // Length settings of the random phases, the clamp cases among them.
    localparam int N_PHASES = 12;
    localparam int PHASE_LEN [N_PHASES] = '{3, 1, 9, 1024, 0, 17, 2047, 40, 6, 1025, 130, 2};

    logic i_clk = 1'b0;
    logic i_rst_n;

    stbs_cfg_if cfg_ch ();
    stbs_in_if  in_ch ();
    stbs_out_if out_ch ();

    sorted_table_bracket_search_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Predictor state: table contents and length register as the core holds them.
    stbs_pkg::t_value   entry_mem [DEPTH];
    stbs_pkg::t_cfg_len len_reg = stbs_pkg::t_cfg_len'(stbs_pkg::LEN_RESET);
    t_expect            bracket_q [$];
    int                 err_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    // Length used by a search: the register clamped between LEN_MIN and the table size.
    function automatic int eff_length(input int raw);
        if (raw < int'(stbs_pkg::LEN_MIN))
            return int'(stbs_pkg::LEN_MIN);
        if (raw > DEPTH)
            return DEPTH;
        return raw;
    endfunction

    // Lower bracket of a key over the current table, as the core computes it.
    function automatic t_expect predict_bracket(input stbs_pkg::t_value key);
        t_expect res;
        int      n;
        int      lo;
        int      hi;
        int      mid;
        n = eff_length(int'(len_reg));
        if (key <= entry_mem[0]) begin
            res.idx = stbs_pkg::BRACKET_LOW;
            res.oc  = stbs_pkg::OUT_BELOW;
        end else if (key >= entry_mem[n-1]) begin
            res.idx = stbs_pkg::t_bracket'(n + int'(stbs_pkg::ABOVE_OFS));
            res.oc  = stbs_pkg::OUT_ABOVE;
        end else begin
            lo = 0;
            hi = n;
            res.oc = stbs_pkg::OUT_INSIDE;
            while (hi - lo > 1) begin
                mid = (hi + lo) / 2;
                if (entry_mem[mid] <= key)
                    lo = mid;
                else
                    hi = mid;
                // The search gives up when it closes on two equal entries.
                if (hi < n && entry_mem[hi] == entry_mem[lo]) begin
                    res.oc = stbs_pkg::OUT_DUP;
                    break;
                end
            end
            res.idx = (res.oc == stbs_pkg::OUT_DUP) ? stbs_pkg::BRACKET_LOW :
                                                      stbs_pkg::t_bracket'(lo);
        end
        return res;
    endfunction

    // Key aimed at the interesting parts of the first n entries.
    function automatic stbs_pkg::t_value pick_key(input int n);
        int     i;
        longint lo_v;
        longint hi_v;
        longint k;
        i = $urandom_range(n - 1);
        case ($urandom_range(9))
            0: k = longint'(stbs_pkg::t_value'($urandom));
            1: k = longint'(entry_mem[0]) - longint'($urandom_range(3));
            2: k = longint'(entry_mem[n-1]) + longint'($urandom_range(3));
            3, 4: k = longint'(entry_mem[i]);
            default: begin
                if (i == n - 1)
                    i = n - 2;
                lo_v = longint'(entry_mem[i]);
                hi_v = longint'(entry_mem[i+1]);
                k = (hi_v > lo_v) ? lo_v + longint'($urandom) % (hi_v - lo_v) : lo_v;
            end
        endcase
        if (k < VAL_MIN)
            k = VAL_MIN;
        if (k > VAL_MAX)
            k = VAL_MAX;
        return stbs_pkg::t_value'(k);
    endfunction

    // Key at or below the first entry, or at or above both the first and the
    // last entry of the full table, so that only those two entries are read.
    function automatic stbs_pkg::t_value pick_end_key();
        longint top;
        longint k;
        top = longint'(entry_mem[0]);
        if (longint'(entry_mem[DEPTH-1]) > top)
            top = longint'(entry_mem[DEPTH-1]);
        if ($urandom_range(1) == 0)
            k = longint'(entry_mem[0]) - longint'($urandom_range(3));
        else
            k = top + longint'($urandom_range(3));
        if (k < VAL_MIN)
            k = VAL_MIN;
        if (k > VAL_MAX)
            k = VAL_MAX;
        return stbs_pkg::t_value'(k);
    endfunction

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send_item(input stbs_pkg::t_op op, input stbs_pkg::t_entry_index idx,
                             input stbs_pkg::t_value val, input stbs_pkg::t_value key,
                             input logic typed, input t_expect want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.entry_index <= idx;
        in_ch.entry_value <= val;
        in_ch.search_key  <= key;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        // Every index of a 10-bit field lies inside a 1024-entry table.
        if (op == stbs_pkg::OP_WRITE)
            entry_mem[idx] = val;
        else
            bracket_q.push_back(typed ? want : predict_bracket(key));
        @(negedge i_clk);
    endtask

    // Stop offering items and let every pending result and write finish.
    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        while (bracket_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(input stbs_pkg::t_cfg_len value);
        settle_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        len_reg = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Load the first n entries with ascending values spread over the full range.
    task automatic fill_ascending(input int n);
        longint step;
        longint v;
        longint prev;
        int     k;
        step = (longint'(1) <<< 32) / (n + 1);
        prev = VAL_MIN;
        for (k = 0; k < n; k++) begin
            if (k > 0 && $urandom_range(9) == 0)
                v = prev;
            else
                v = VAL_MIN + k * step + longint'($urandom_range(32'(step - 1)));
            send_item(stbs_pkg::OP_WRITE, stbs_pkg::t_entry_index'(k),
                      stbs_pkg::t_value'(v), stbs_pkg::t_value'($urandom), 1'b0, '0);
            prev = v;
        end
    endtask

    // Receiver side: ready is redrawn every cycle.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_expect want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (bracket_q.size() == 0) begin
                $display("%0t: unexpected result index %0d outcome %0d", $time,
                         out_ch.bracket_index, out_ch.outcome);
                err_count++;
            end else begin
                want = bracket_q.pop_front();
                if (out_ch.bracket_index !== want.idx) begin
                    $display("%0t: bracket_index expected %0d actual %0d", $time,
                             want.idx, out_ch.bracket_index);
                    err_count++;
                end
                if (out_ch.outcome !== want.oc) begin
                    $display("%0t: outcome expected %0d actual %0d", $time,
                             want.oc, out_ch.outcome);
                    err_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, final check.
    initial begin
        int      p;
        int      r;
        int      n;
        t_expect want;
        i_rst_n           = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        in_ch.valid       = 1'b0;
        in_ch.op          = stbs_pkg::OP_WRITE;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        in_ch.search_key  = '0;
        out_ch.ready      = 1'b0;
        foreach (entry_mem[i])
            entry_mem[i] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 84;
        for (r = 0; r < N_ROWS; r++) begin
            if (DIR_ROWS[r].is_cfg) begin
                write_length(DIR_ROWS[r].cfg);
            end else begin
                want.idx = DIR_ROWS[r].eidx;
                want.oc  = DIR_ROWS[r].eout;
                send_item(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].val,
                          DIR_ROWS[r].key, DIR_ROWS[r].typed, want);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 21;
            end else if (p == 2 * N_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_length(stbs_pkg::t_cfg_len'(PHASE_LEN[p]));
            n = eff_length(PHASE_LEN[p]);
            // Large tables are not loaded: the directed part wrote the last
            // entry, and their searches stay at the first and the last entry.
            if (n <= BIG_LENGTH)
                fill_ascending(n);
            for (r = 0; r < SEARCHES; r++) begin
                if ($urandom_range(7) == 0) begin
                    send_item(stbs_pkg::OP_WRITE,
                              stbs_pkg::t_entry_index'($urandom_range(DEPTH - 1)),
                              stbs_pkg::t_value'($urandom), stbs_pkg::t_value'($urandom),
                              1'b0, '0);
                end else if (n <= BIG_LENGTH) begin
                    send_item(stbs_pkg::OP_SEARCH, stbs_pkg::t_entry_index'($urandom),
                              stbs_pkg::t_value'($urandom), pick_key(n), 1'b0, '0);
                end else begin
                    send_item(stbs_pkg::OP_SEARCH, stbs_pkg::t_entry_index'($urandom),
                              stbs_pkg::t_value'($urandom), pick_end_key(), 1'b0, '0);
                end
            end
        end

        settle_idle();
        if (err_count == 0)
            $display("sorted_table_bracket_search_core test passed");
        else
            $display("sorted_table_bracket_search_core test failed");
        $finish;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("sorted_table_bracket_search_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/stbs_pkg.sv
rtl/core/stbs_in_if.sv
rtl/core/stbs_out_if.sv
rtl/core/stbs_cfg_if.sv
rtl/core/stbs_ram.sv
rtl/core/stbs_ctrl.sv
rtl/core/stbs_dp.sv
rtl/core/sorted_table_bracket_search_core.sv
tb/tb.sv
